FILE: hw/rtl/rpm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and constant functions for the radar point transform.
package rpm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int NUM_SENSORS   = 5;
  localparam int POSE_ENTRIES  = 8;

  localparam int ANG_W = 31;
  localparam int CS_W  = 33;
  localparam int X1_W  = 22;
  localparam int SUM_W = 56;
  localparam int RND_W = 27;

  localparam logic signed [ANG_W-1:0] ANG_PI      = 31'sd843314857;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 31'sd421657428;
  localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 33'sd652032874;
  localparam logic [24:0]             KRAD        = 25'd20122276;
  localparam logic [36:0]             VEL_BIAS    = 37'd976562;
  localparam logic [20:0]             VEL_DIV     = 21'd1953125;
  localparam logic [19:0]             VEL_RECIP   = 20'd562949;
  localparam logic signed [19:0]      POS_MAX     = 20'sd524287;
  localparam logic signed [19:0]      POS_MIN     = -20'sd524288;

  localparam int BK_LAST = CORDIC_STAGES + 5;

  typedef enum logic [1:0] {
    CFG_VELOCITY_X = 2'd0,
    CFG_VELOCITY_Y = 2'd1,
    CFG_YAW_RATE   = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_t;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [24] = '{
    31'sd210828714, 31'sd124459457, 31'sd65760959, 31'sd33381290,
    31'sd16755422,  31'sd8385879,   31'sd4193963,  31'sd2097109,
    31'sd1048571,   31'sd524287,    31'sd262144,   31'sd131072,
    31'sd65536,     31'sd32768,     31'sd16384,    31'sd8192,
    31'sd4096,      31'sd2048,      31'sd1024,     31'sd512,
    31'sd256,       31'sd128,       31'sd64,       31'sd32
  };

  localparam logic signed [ANG_W-1:0] MOUNT_ANG [POSE_ENTRIES] = '{
    31'sd805306, 31'sd413927473, -31'sd426275504, 31'sd817117528,
    -31'sd825170592, 31'sd0, 31'sd0, 31'sd0
  };
  localparam logic signed [12:0] MOUNT_TX [POSE_ENTRIES] = '{
    13'sd3494, 13'sd2480, 13'sd2480, -13'sd575, -13'sd575, 13'sd0, 13'sd0, 13'sd0
  };
  localparam logic signed [12:0] MOUNT_TY [POSE_ENTRIES] = '{
    13'sd0, 13'sd819, -13'sd819, 13'sd643, -13'sd633, 13'sd0, 13'sd0, 13'sd0
  };

  // Elaboration-time CORDIC, same folding and iteration as the hardware.
  function automatic logic signed [CS_W-1:0] cordic_run(
    input logic signed [ANG_W-1:0] ang, input logic want_sin);
    longint x, y, z, dx, dy;
    logic   flip;
    x = CORDIC_GAIN;
    y = 0;
    z = ang;
    flip = 1'b0;
    if (z > ANG_HALF_PI) begin
      z = z - ANG_PI;
      flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z = z + ANG_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    return want_sin ? CS_W'(y) : CS_W'(x);
  endfunction

  localparam logic signed [CS_W-1:0] MOUNT_COS [POSE_ENTRIES] = '{
    cordic_run(MOUNT_ANG[0], 1'b0), cordic_run(MOUNT_ANG[1], 1'b0),
    cordic_run(MOUNT_ANG[2], 1'b0), cordic_run(MOUNT_ANG[3], 1'b0),
    cordic_run(MOUNT_ANG[4], 1'b0), cordic_run(MOUNT_ANG[5], 1'b0),
    cordic_run(MOUNT_ANG[6], 1'b0), cordic_run(MOUNT_ANG[7], 1'b0)
  };
  localparam logic signed [CS_W-1:0] MOUNT_SIN [POSE_ENTRIES] = '{
    cordic_run(MOUNT_ANG[0], 1'b1), cordic_run(MOUNT_ANG[1], 1'b1),
    cordic_run(MOUNT_ANG[2], 1'b1), cordic_run(MOUNT_ANG[3], 1'b1),
    cordic_run(MOUNT_ANG[4], 1'b1), cordic_run(MOUNT_ANG[5], 1'b1),
    cordic_run(MOUNT_ANG[6], 1'b1), cordic_run(MOUNT_ANG[7], 1'b1)
  };

  // Round half away from zero, dropping 30 fraction bits.
  function automatic logic signed [RND_W-1:0] round_q30(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] mag;
    logic [SUM_W-1:0] q;
    mag = v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
    q = (mag + (SUM_W'(1) << 29)) >> 30;
    return v[SUM_W-1] ? -RND_W'(q) : RND_W'(q);
  endfunction

  typedef struct packed {
    logic signed [X1_W-1:0] x1;
    logic signed [X1_W-1:0] y1;
    logic [17:0]            td;
    logic signed [7:0]      cs;
    logic                   inv;
  } fr_t;

  typedef struct packed {
    logic signed [X1_W-1:0]  x1;
    logic signed [X1_W-1:0]  y1;
    logic [17:0]             td;
    logic signed [7:0]       cs;
    logic                    inv;
    logic                    neg_a;
    logic                    neg_x;
    logic                    neg_y;
    logic [37:0]             am;
    logic [35:0]             vxm;
    logic [35:0]             vym;
    logic [40:0]             pp_lo;
    logic [46:0]             pp_hi;
    logic [36:0]             mx;
    logic [36:0]             my;
    logic signed [ANG_W-1:0] ang;
    logic [17:0]             qx0;
    logic [17:0]             qy0;
    logic [38:0]             prx;
    logic [38:0]             pry;
    logic signed [17:0]      shx;
    logic signed [17:0]      shy;
    logic signed [CS_W-1:0]  cx;
    logic signed [CS_W-1:0]  cy;
    logic signed [ANG_W-1:0] cz;
    logic                    flip;
    logic signed [54:0]      m_cx;
    logic signed [54:0]      m_sy;
    logic signed [54:0]      m_sx;
    logic signed [54:0]      m_cy;
    logic signed [19:0]      xo;
    logic signed [19:0]      yo;
  } bk_t;

endpackage

FILE: hw/rtl/rpm_front.sv
`timescale 1ns / 1ps
// Front end: accept a detection, look up its mount pose, apply the mount transform.
module rpm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_sensor_index,
  input  logic [17:0]         in_time_offset,
  input  logic signed [19:0]  in_point_x,
  input  logic signed [19:0]  in_point_y,
  input  logic signed [7:0]   in_cross_section,
  input  logic                in_invalid_flag,
  output logic                fr_valid,
  input  logic                fr_full,
  output rpm_pkg::fr_t        fr_item
);

  logic                     en;
  logic                     f1_v_r;
  logic signed [52:0]       pcx_r, psy_r, psx_r, pcy_r;
  logic signed [12:0]       tx_r, ty_r;
  logic [17:0]              td_r;
  logic signed [7:0]        cs_r;
  logic                     inv_r;
  logic                     f2_v_r;
  rpm_pkg::fr_t             f2_r, f2_nxt;
  logic signed [rpm_pkg::CS_W-1:0] c_sel, s_sel;
  logic signed [rpm_pkg::SUM_W-1:0] sx, sy;

  // Hold the whole front while the finished word cannot enter the queue.
  assign en       = !(f2_v_r && fr_full);
  assign in_stall = !en;
  assign c_sel    = rpm_pkg::MOUNT_COS[in_sensor_index];
  assign s_sel    = rpm_pkg::MOUNT_SIN[in_sensor_index];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= in_valid;
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcx_r <= 53'(c_sel * in_point_x);
      psy_r <= 53'(s_sel * in_point_y);
      psx_r <= 53'(s_sel * in_point_x);
      pcy_r <= 53'(c_sel * in_point_y);
      tx_r  <= rpm_pkg::MOUNT_TX[in_sensor_index];
      ty_r  <= rpm_pkg::MOUNT_TY[in_sensor_index];
      td_r  <= in_time_offset;
      cs_r  <= in_cross_section;
      inv_r <= in_invalid_flag;
      f2_r  <= f2_nxt;
    end
  end

  always_comb begin
    sx = rpm_pkg::SUM_W'(pcx_r) - rpm_pkg::SUM_W'(psy_r);
    sy = rpm_pkg::SUM_W'(psx_r) + rpm_pkg::SUM_W'(pcy_r);
    f2_nxt.x1  = rpm_pkg::X1_W'(rpm_pkg::round_q30(sx)) + rpm_pkg::X1_W'(tx_r);
    f2_nxt.y1  = rpm_pkg::X1_W'(rpm_pkg::round_q30(sy)) + rpm_pkg::X1_W'(ty_r);
    f2_nxt.td  = td_r;
    f2_nxt.cs  = cs_r;
    f2_nxt.inv = inv_r;
  end

  assign fr_valid = f2_v_r;
  assign fr_item  = f2_r;

endmodule

FILE: hw/rtl/rpm_queue.sv
`timescale 1ns / 1ps
// Four-entry queue between the front and back ends.
module rpm_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  rpm_pkg::fr_t din,
  input  logic         pop,
  output rpm_pkg::fr_t dout,
  output logic         full,
  output logic         empty
);

  rpm_pkg::fr_t mem_r [4];
  logic [1:0]   wp_r, rp_r;
  logic [2:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign dout  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 3'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

endmodule

FILE: hw/rtl/rpm_back.sv
`timescale 1ns / 1ps
// Back end: motion angle, velocity shift, CORDIC, motion rotation and saturation.
module rpm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [17:0] vel_x,
  input  logic signed [17:0] vel_y,
  input  logic signed [19:0] yaw,
  input  logic               q_empty,
  input  rpm_pkg::fr_t       q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] out_x_out,
  output logic signed [19:0] out_y_out,
  output logic signed [7:0]  out_intensity_out,
  output logic               out_invalid_out
);

  localparam int N    = rpm_pkg::CORDIC_STAGES;
  localparam int LAST = rpm_pkg::BK_LAST;

  rpm_pkg::bk_t bk_r   [LAST+1];
  rpm_pkg::bk_t bk_nxt [LAST+1];
  logic         bv_r   [LAST+1];
  logic         en;

  // Advance every stage together unless the output word is held.
  assign en    = !(bv_r[LAST] && out_stall);
  assign q_pop = en && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) bv_r[i] <= 1'b0;
    end else if (en) begin
      bv_r[0] <= !q_empty;
      for (int i = 1; i <= LAST; i++) bv_r[i] <= bv_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= LAST; i++) bk_r[i] <= bk_nxt[i];
    end
  end

  // Intake: magnitudes of rate times offset.
  always_comb begin
    logic [19:0] ya;
    logic [17:0] xa, ybs;
    ya  = yaw[19] ? 20'(-yaw) : 20'(yaw);
    xa  = vel_x[17] ? 18'(-vel_x) : 18'(vel_x);
    ybs = vel_y[17] ? 18'(-vel_y) : 18'(vel_y);
    bk_nxt[0]       = '0;
    bk_nxt[0].x1    = q_item.x1;
    bk_nxt[0].y1    = q_item.y1;
    bk_nxt[0].td    = q_item.td;
    bk_nxt[0].cs    = q_item.cs;
    bk_nxt[0].inv   = q_item.inv;
    bk_nxt[0].neg_a = yaw[19];
    bk_nxt[0].neg_x = vel_x[17];
    bk_nxt[0].neg_y = vel_y[17];
    bk_nxt[0].am    = 38'(ya * q_item.td);
    bk_nxt[0].vxm   = 36'(xa * q_item.td);
    bk_nxt[0].vym   = 36'(ybs * q_item.td);
  end

  for (genvar gi = 1; gi <= LAST; gi++) begin : g_stage
    if (gi == 1) begin : g_split
      always_comb begin
        bk_nxt[gi]       = bk_r[gi-1];
        bk_nxt[gi].pp_lo = 41'(bk_r[gi-1].am[15:0] * rpm_pkg::KRAD);
        bk_nxt[gi].pp_hi = 47'(bk_r[gi-1].am[37:16] * rpm_pkg::KRAD);
        bk_nxt[gi].mx    = {bk_r[gi-1].vxm, 1'b0} + rpm_pkg::VEL_BIAS;
        bk_nxt[gi].my    = {bk_r[gi-1].vym, 1'b0} + rpm_pkg::VEL_BIAS;
      end
    end else if (gi == 2) begin : g_angle
      always_comb begin
        logic [62:0] sum;
        logic [30:0] mag;
        sum = (63'(bk_r[gi-1].pp_hi) << 16) + 63'(bk_r[gi-1].pp_lo);
        mag = 31'((sum + (63'(1) << 31)) >> 32);
        bk_nxt[gi]     = bk_r[gi-1];
        bk_nxt[gi].ang = bk_r[gi-1].neg_a ? -$signed(mag) : $signed(mag);
        bk_nxt[gi].qx0 = 18'((41'(bk_r[gi-1].mx[36:16]) * 41'(rpm_pkg::VEL_RECIP)) >> 24);
        bk_nxt[gi].qy0 = 18'((41'(bk_r[gi-1].my[36:16]) * 41'(rpm_pkg::VEL_RECIP)) >> 24);
      end
    end else if (gi == 3) begin : g_fold
      always_comb begin
        logic signed [rpm_pkg::ANG_W-1:0] a;
        a = bk_r[gi-1].ang;
        bk_nxt[gi]      = bk_r[gi-1];
        bk_nxt[gi].cx   = rpm_pkg::CORDIC_GAIN;
        bk_nxt[gi].cy   = '0;
        bk_nxt[gi].cz   = a;
        bk_nxt[gi].flip = 1'b0;
        if (a > rpm_pkg::ANG_HALF_PI) begin
          bk_nxt[gi].cz   = a - rpm_pkg::ANG_PI;
          bk_nxt[gi].flip = 1'b1;
        end else if (a < -rpm_pkg::ANG_HALF_PI) begin
          bk_nxt[gi].cz   = a + rpm_pkg::ANG_PI;
          bk_nxt[gi].flip = 1'b1;
        end
        bk_nxt[gi].prx = 39'(bk_r[gi-1].qx0 * rpm_pkg::VEL_DIV);
        bk_nxt[gi].pry = 39'(bk_r[gi-1].qy0 * rpm_pkg::VEL_DIV);
      end
    end else if (gi <= N + 3) begin : g_cordic
      always_comb begin
        logic signed [rpm_pkg::CS_W-1:0]  x, y, dx, dy;
        logic signed [rpm_pkg::ANG_W-1:0] z;
        logic [38:0] rx, ry;
        logic [17:0] qx, qy;
        x  = bk_r[gi-1].cx;
        y  = bk_r[gi-1].cy;
        z  = bk_r[gi-1].cz;
        dx = y >>> (gi - 4);
        dy = x >>> (gi - 4);
        rx = {2'b00, bk_r[gi-1].mx} - bk_r[gi-1].prx;
        ry = {2'b00, bk_r[gi-1].my} - bk_r[gi-1].pry;
        qx = (rx >= 39'(rpm_pkg::VEL_DIV)) ? bk_r[gi-1].qx0 + 18'd1 : bk_r[gi-1].qx0;
        qy = (ry >= 39'(rpm_pkg::VEL_DIV)) ? bk_r[gi-1].qy0 + 18'd1 : bk_r[gi-1].qy0;
        bk_nxt[gi] = bk_r[gi-1];
        if (z >= 0) begin
          bk_nxt[gi].cx = x - dx;
          bk_nxt[gi].cy = y + dy;
          bk_nxt[gi].cz = z - rpm_pkg::ATAN_TAB[gi-4];
        end else begin
          bk_nxt[gi].cx = x + dx;
          bk_nxt[gi].cy = y - dy;
          bk_nxt[gi].cz = z + rpm_pkg::ATAN_TAB[gi-4];
        end
        // Finish the velocity quotient once, in the first rotation step.
        if (gi == 4) begin
          bk_nxt[gi].shx = bk_r[gi-1].neg_x ? -$signed(qx) : $signed(qx);
          bk_nxt[gi].shy = bk_r[gi-1].neg_y ? -$signed(qy) : $signed(qy);
        end
      end
    end else if (gi == N + 4) begin : g_mult
      always_comb begin
        logic signed [rpm_pkg::CS_W-1:0] c, s;
        c = bk_r[gi-1].flip ? -bk_r[gi-1].cx : bk_r[gi-1].cx;
        s = bk_r[gi-1].flip ? -bk_r[gi-1].cy : bk_r[gi-1].cy;
        bk_nxt[gi]      = bk_r[gi-1];
        bk_nxt[gi].m_cx = 55'(c * bk_r[gi-1].x1);
        bk_nxt[gi].m_sy = 55'(s * bk_r[gi-1].y1);
        bk_nxt[gi].m_sx = 55'(s * bk_r[gi-1].x1);
        bk_nxt[gi].m_cy = 55'(c * bk_r[gi-1].y1);
      end
    end else begin : g_final
      always_comb begin
        logic signed [rpm_pkg::SUM_W-1:0] sx, sy;
        logic signed [27:0] fx, fy;
        sx = rpm_pkg::SUM_W'(bk_r[gi-1].m_cx) - rpm_pkg::SUM_W'(bk_r[gi-1].m_sy);
        sy = rpm_pkg::SUM_W'(bk_r[gi-1].m_sx) + rpm_pkg::SUM_W'(bk_r[gi-1].m_cy);
        fx = 28'(rpm_pkg::round_q30(sx)) + 28'(bk_r[gi-1].shx);
        fy = 28'(rpm_pkg::round_q30(sy)) + 28'(bk_r[gi-1].shy);
        bk_nxt[gi] = bk_r[gi-1];
        if (fx > 28'(rpm_pkg::POS_MAX)) bk_nxt[gi].xo = rpm_pkg::POS_MAX;
        else if (fx < 28'(rpm_pkg::POS_MIN)) bk_nxt[gi].xo = rpm_pkg::POS_MIN;
        else bk_nxt[gi].xo = fx[19:0];
        if (fy > 28'(rpm_pkg::POS_MAX)) bk_nxt[gi].yo = rpm_pkg::POS_MAX;
        else if (fy < 28'(rpm_pkg::POS_MIN)) bk_nxt[gi].yo = rpm_pkg::POS_MIN;
        else bk_nxt[gi].yo = fy[19:0];
      end
    end
  end

  assign out_valid         = bv_r[LAST];
  assign out_x_out         = bk_r[LAST].xo;
  assign out_y_out         = bk_r[LAST].yo;
  assign out_intensity_out = bk_r[LAST].cs;
  assign out_invalid_out   = bk_r[LAST].inv;

endmodule

FILE: hw/rtl/radar_point_mount_and_motion_transform_top.sv
`timescale 1ns / 1ps
// Top level of the radar point mount and motion-compensation transform.
//
// Takes one radar detection word per cycle while in_stall is low and
// returns one corrected point word per detection, in order. The front end
// (two stages) looks up the sensor's mounting pose from a constant table
// and rotates and shifts the point into the vehicle frame; a four-entry
// queue then decouples it from the back end (CORDIC_STAGES + 6 stages),
// which derives the motion angle from yaw rate times time offset, runs a
// pipelined CORDIC for its sine and cosine, divides velocity times offset
// by a constant reciprocal, rotates, shifts and saturates. Throughput is
// one word per cycle when nothing stalls; a word passes both front stages,
// is written into the queue and is taken from its head by the back end's
// intake stage. A held output (out_stall) freezes the back end, the queue
// absorbs up to four words, then in_stall rises. Sensor indexes above four
// use the identity pose. Write velocity_x, velocity_y and yaw_rate
// (cfg_index 0, 1, 2) only while no word is in flight; they reset to zero.
module radar_point_mount_and_motion_transform_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_sensor_index,
  input  logic [17:0]        in_time_offset,
  input  logic signed [19:0] in_point_x,
  input  logic signed [19:0] in_point_y,
  input  logic signed [7:0]  in_cross_section,
  input  logic               in_invalid_flag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] out_x_out,
  output logic signed [19:0] out_y_out,
  output logic signed [7:0]  out_intensity_out,
  output logic               out_invalid_out,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [19:0]        cfg_wdata
);

  logic signed [17:0] vel_x_r, vel_y_r;
  logic signed [19:0] yaw_r;
  logic               fr_valid, q_full, q_empty, q_pop, q_push;
  rpm_pkg::fr_t       fr_item, q_item;

  // Configuration registers; writes to the unused index drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_x_r <= '0;
      vel_y_r <= '0;
      yaw_r   <= '0;
    end else if (cfg_we) begin
      unique case (rpm_pkg::cfg_idx_t'(cfg_index))
        rpm_pkg::CFG_VELOCITY_X: vel_x_r <= cfg_wdata[17:0];
        rpm_pkg::CFG_VELOCITY_Y: vel_y_r <= cfg_wdata[17:0];
        rpm_pkg::CFG_YAW_RATE:   yaw_r   <= cfg_wdata;
        rpm_pkg::CFG_UNUSED:     ;
      endcase
    end
  end

  // Mount transform.
  rpm_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sensor_index  (in_sensor_index),
    .in_time_offset   (in_time_offset),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_cross_section (in_cross_section),
    .in_invalid_flag  (in_invalid_flag),
    .fr_valid         (fr_valid),
    .fr_full          (q_full),
    .fr_item          (fr_item)
  );

  // Push whenever the front end holds a finished word and there is room.
  assign q_push = fr_valid && !q_full;

  rpm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (fr_item),
    .pop   (q_pop),
    .dout  (q_item),
    .full  (q_full),
    .empty (q_empty)
  );

  // Motion compensation and output register.
  rpm_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .vel_x             (vel_x_r),
    .vel_y             (vel_y_r),
    .yaw               (yaw_r),
    .q_empty           (q_empty),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_x_out         (out_x_out),
    .out_y_out         (out_y_out),
    .out_intensity_out (out_intensity_out),
    .out_invalid_out   (out_invalid_out)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the radar point mount and motion-compensation transform.
module tb_top;

  // One detection word on the input side.
  typedef struct {
    logic [2:0]         sensor;
    logic [17:0]        toff;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [7:0]  rcs;
    logic               inv;
  } detection_t;

  // One corrected point word on the output side.
  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [7:0]  rcs;
    logic               inv;
  } point_t;

  localparam longint ANGLE_PI      = 843314857;
  localparam longint ANGLE_HALF_PI = 421657428;
  localparam longint INV_GAIN_Q30  = 652032874;
  localparam longint RAD_PER_MDEG  = 20122276;
  localparam longint NS_PER_S      = 1000000000;
  localparam int     LATENCY       = rpm_pkg::CORDIC_STAGES + 16;
  localparam int     CYCLE_LIMIT   = 600000;

  // Arctangent of 2^-i in Q28 radians.
  localparam longint ARCTAN_Q28 [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963, 2097109,
    1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32
  };
  // Mounting pose per sensor: angle Q28, shift in 1/1024 m. Entries 5..7 are identity.
  localparam longint POSE_ANGLE [8] = '{805306, 413927473, -426275504, 817117528,
                                        -825170592, 0, 0, 0};
  localparam longint POSE_DX [8] = '{3494, 2480, 2480, -575, -575, 0, 0, 0};
  localparam longint POSE_DY [8] = '{0, 819, -819, 643, -633, 0, 0, 0};

  logic clk;
  logic rst_n;
  logic in_valid, in_stall;
  logic [2:0] in_sensor_index;
  logic [17:0] in_time_offset;
  logic signed [19:0] in_point_x, in_point_y;
  logic signed [7:0] in_cross_section;
  logic in_invalid_flag;
  logic out_valid, out_stall;
  logic signed [19:0] out_x_out, out_y_out;
  logic signed [7:0] out_intensity_out;
  logic out_invalid_out;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [19:0] cfg_wdata;

  radar_point_mount_and_motion_transform_top uut (.*);

  // Mirror of the ego-motion registers, updated on every write.
  logic signed [17:0] ego_vx, ego_vy;
  logic signed [19:0] ego_yaw;

  detection_t pending_words[$];
  point_t     expected_points[$];
  int         error_count;
  int         points_checked;
  int         cycle_count;
  bit         no_idle;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint round_shift(input longint v, input int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint round_div(input longint v, input longint d);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + d / 2) / d;
    return (v < 0) ? -mag : mag;
  endfunction

  // Rotation-mode CORDIC, folded into [-pi/2, pi/2] first.
  function automatic void sin_cos(input longint ang, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = INV_GAIN_Q30;
    y = 0;
    z = ang;
    flip = 1'b0;
    if (z > ANGLE_HALF_PI) begin
      z -= ANGLE_PI;
      flip = 1'b1;
    end else if (z < -ANGLE_HALF_PI) begin
      z += ANGLE_PI;
      flip = 1'b1;
    end
    for (int i = 0; i < rpm_pkg::CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q28[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q28[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic signed [19:0] clamp_pos(input longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return 20'(v);
  endfunction

  // Mount transform, then motion rotation and shift over the time offset.
  function automatic point_t transform_point(input detection_t d);
    point_t r;
    longint c, s, x1, y1, x2, y2, td, px, py, ang;
    td = longint'(d.toff);
    px = longint'(d.px);
    py = longint'(d.py);
    sin_cos(POSE_ANGLE[d.sensor], c, s);
    x1 = round_shift(c * px - s * py, 30) + POSE_DX[d.sensor];
    y1 = round_shift(s * px + c * py, 30) + POSE_DY[d.sensor];
    ang = round_shift(longint'(ego_yaw) * td * RAD_PER_MDEG, 32);
    sin_cos(ang, c, s);
    x2 = round_shift(c * x1 - s * y1, 30) + round_div(longint'(ego_vx) * td * 1024, NS_PER_S);
    y2 = round_shift(s * x1 + c * y1, 30) + round_div(longint'(ego_vy) * td * 1024, NS_PER_S);
    r.x = clamp_pos(x2);
    r.y = clamp_pos(y2);
    r.rcs = d.rcs;
    r.inv = d.inv;
    return r;
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: hold the word until accepted, then advance to the next pending one.
  int send_gap;
  always @(posedge clk) begin
    logic busy;
    detection_t d;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        d.sensor = in_sensor_index;
        d.toff = in_time_offset;
        d.px = in_point_x;
        d.py = in_point_y;
        d.rcs = in_cross_section;
        d.inv = in_invalid_flag;
        expected_points.insert(expected_points.size(), transform_point(d));
        busy = 1'b0;
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          d = pending_words.pop_front();
          in_sensor_index  <= d.sensor;
          in_time_offset   <= d.toff;
          in_point_x       <= d.px;
          in_point_y       <= d.py;
          in_cross_section <= d.rcs;
          in_invalid_flag  <= d.inv;
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted point with the oldest expectation, then pick a stall.
  int stall_left;
  always @(posedge clk) begin
    point_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d rcs=%0d inv=%0b", $time,
                   out_x_out, out_y_out, out_intensity_out, out_invalid_out);
          error_count++;
        end else begin
          e = expected_points.pop_front();
          points_checked++;
          if (e.x !== out_x_out || e.y !== out_y_out || e.rcs !== out_intensity_out ||
              e.inv !== out_invalid_out) begin
            $display("%0t: expected x=%0d y=%0d rcs=%0d inv=%0b, got x=%0d y=%0d rcs=%0d inv=%0b",
                     $time, e.x, e.y, e.rcs, e.inv,
                     out_x_out, out_y_out, out_intensity_out, out_invalid_out);
            error_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d points outstanding", $time, expected_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(input rpm_pkg::cfg_idx_t idx, input longint value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 20'(value);
    case (idx)
      rpm_pkg::CFG_VELOCITY_X: ego_vx <= 18'(value);
      rpm_pkg::CFG_VELOCITY_Y: ego_vy <= 18'(value);
      rpm_pkg::CFG_YAW_RATE:   ego_yaw <= 20'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_motion(input longint vx, input longint vy, input longint yaw);
    write_reg(rpm_pkg::CFG_VELOCITY_X, vx);
    write_reg(rpm_pkg::CFG_VELOCITY_Y, vy);
    write_reg(rpm_pkg::CFG_YAW_RATE, yaw);
  endtask

  task automatic queue_word(input int sensor, input int toff, input int px, input int py,
                            input int rcs, input int inv);
    detection_t d;
    d.sensor = 3'(sensor);
    d.toff = 18'(toff);
    d.px = 20'(px);
    d.py = 20'(py);
    d.rcs = 8'(rcs);
    d.inv = 1'(inv);
    pending_words.insert(pending_words.size(), d);
  endtask

  // Well-formed sensors mostly, with some identity-pose indexes mixed in.
  task automatic queue_random(input int count);
    int toff, sensor;
    for (int i = 0; i < count; i++) begin
      sensor = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      toff = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 262143) : $urandom_range(0, 100000);
      queue_word(sensor, toff, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Drain: wait for every expected point, then let the pipeline settle.
  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_points.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sensor_index = '0;
    in_time_offset = '0;
    in_point_x = '0;
    in_point_y = '0;
    in_cross_section = '0;
    in_invalid_flag = 1'b0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = rpm_pkg::CFG_VELOCITY_X;
    cfg_wdata = '0;
    ego_vx = '0;
    ego_vy = '0;
    ego_yaw = '0;
    error_count = 0;
    points_checked = 0;
    cycle_count = 0;
    no_idle = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every sensor including identity indexes, field extremes, saturation.
    set_motion(100000, -100000, 360000);
    for (int s = 0; s < 8; s++) queue_word(s, 262143, 1000, -2000, s * 30 - 128, s & 1);
    queue_word(0, 0, 524287, 0, 127, 0);
    queue_word(0, 0, -524288, -524288, -128, 1);
    queue_word(3, 262143, 524287, 524287, 0, 0);
    queue_word(4, 262143, -524288, 524287, 1, 1);
    queue_word(1, 0, 0, 0, -1, 0);
    queue_word(2, 131072, -524288, 0, 64, 1);
    queue_word(7, 262143, 524287, -524288, -64, 0);
    drain();

    // Register extremes, both signs, then the full two's-complement reach.
    set_motion(-100000, 100000, -360000);
    queue_random(80);
    drain();
    set_motion(131071, -131072, 524287);
    queue_random(60);
    drain();
    set_motion(-131072, 131071, -524288);
    queue_random(60);
    drain();
    set_motion(0, 0, 0);
    queue_random(60);
    drain();

    // Random motion settings; one phase runs with no idling on either side.
    for (int p = 0; p < 6; p++) begin
      no_idle = (p == 2);
      set_motion(longint'($urandom_range(0, 200000)) - 100000,
                 longint'($urandom_range(0, 200000)) - 100000,
                 longint'($urandom_range(0, 720000)) - 360000);
      queue_random(90);
      drain();
    end

    $display("Covered %0d points over 11 motion settings, all sensors and identity indexes,",
             points_checked);
    $display("register and field extremes, saturation and random stalls on both sides.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
